[hw/rtl/mavg_pkg.sv]
package mavg_pkg;

    // Width of the window length register
    localparam int CFG_W = 7;

    // Window length after reset
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

    // Command codes carried on s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic cfg_write;   // load window length, empty the window
        logic clear;       // empty the window
        logic accept;      // latch sample, read oldest entry
        logic update;      // update sum, count, position, store
        logic div_load;    // start divide of sum by count
        logic div_step;    // one quotient bit
        logic out_load;    // move quotient into output register
    } mavg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register empty or being drained
    } mavg_status_t;

endpackage

[hw/rtl/moving_average_filter.sv]
// Boxcar moving average with a running sum. Each sample beat (s_tuser = 0)
// writes the sample into a ring store, updates the running sum (adding the
// new sample, and once the window is full subtracting the overwritten oldest
// one) and returns the sum divided by the number of samples held, truncated
// toward zero. A clear beat (s_tuser = 1) empties the window and returns
// nothing. Writing the window length on the cfg channel also empties the
// window; a length of 0 acts as 1, one above STORE_DEPTH acts as
// STORE_DEPTH. The average comes from a restoring divider that yields one
// quotient bit per cycle; SUM_W is SAMPLE_WIDTH plus log2 of the largest
// window. The output register lets the next sample start while a result
// waits on m_tready.
module moving_average_filter #(
    parameter int  STORE_DEPTH  = 64,
    parameter int  SAMPLE_WIDTH = 16,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input beats
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [TDATA_W-1:0]         s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                       s_tuser,   // [0] command
    // result beats
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // [SAMPLE_WIDTH-1:0] average
    // window length register
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mavg_pkg::CFG_W-1:0] cfg_data
);
    import mavg_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int LEN_MAX = (STORE_DEPTH < CFG_MAX) ? STORE_DEPTH : CFG_MAX;
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(LEN_MAX);

    mavg_cmd_t               cmd;
    mavg_status_t            status;
    logic [SAMPLE_WIDTH-1:0] average;

    mavg_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_command (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mavg_datapath #(
        .STORE_DEPTH  (STORE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_data (cfg_data),
        .sample   (s_tdata[SAMPLE_WIDTH-1:0]),
        .average  (average),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready)
    );

    // pad bits above the average read as zero
    assign m_tdata = TDATA_W'(average);

endmodule

[hw/rtl/mavg_datapath.sv]
module mavg_datapath #(
    parameter int STORE_DEPTH  = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mavg_pkg::mavg_cmd_t           cmd,
    output mavg_pkg::mavg_status_t        status,
    input  logic [mavg_pkg::CFG_W-1:0]    cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]       sample,
    output logic [SAMPLE_WIDTH-1:0]       average,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import mavg_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int LEN_MAX = (STORE_DEPTH < CFG_MAX) ? STORE_DEPTH : CFG_MAX;
    localparam int COUNT_W = $clog2(LEN_MAX + 1);
    localparam int PTR_W   = $clog2(STORE_DEPTH);
    localparam int POS_W   = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(LEN_MAX);

    logic [SAMPLE_WIDTH-1:0]        store_mem [STORE_DEPTH];

    logic [CFG_W-1:0]               win_reg;
    logic [COUNT_W-1:0]             len;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [COUNT_W-1:0]             fill_reg, fill_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic                           full;

    logic                           neg_reg;
    logic [SUM_W-1:0]               quo_reg;
    logic [COUNT_W-1:0]             rem_reg;
    logic [COUNT_W:0]               rem_shift;
    logic [COUNT_W:0]               divisor;
    logic                           fits;

    logic [SAMPLE_WIDTH-1:0]        avg_reg;
    logic                           m_valid_reg;

    // Window length clamped to 1..LEN_MAX
    always_comb begin
        if (win_reg == '0) begin
            len = COUNT_W'(1);
        end else if (int'(win_reg) > LEN_MAX) begin
            len = COUNT_W'(LEN_MAX);
        end else begin
            len = COUNT_W'(win_reg);
        end
    end

    assign full = (fill_reg == len);

    always_comb begin
        if (full) begin
            sum_next  = sum_reg - SUM_W'(old_reg) + SUM_W'(sample_reg);
            fill_next = fill_reg;
        end else begin
            sum_next  = sum_reg + SUM_W'(sample_reg);
            fill_next = fill_reg + COUNT_W'(1);
        end
        if ((pos_reg + POS_W'(1)) == POS_W'(len)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Restoring divide step, divisor is the sample count (never zero here)
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign divisor   = {1'b0, fill_reg};
    assign fits      = (rem_shift >= divisor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WINDOW_RESET;
            pos_reg     <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cfg_write) begin
                win_reg <= cfg_data;
            end
            if (cmd.cfg_write || cmd.clear) begin
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end else if (cmd.update) begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Sample store: oldest entry read on accept, new sample written on update
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            old_reg <= store_mem[pos_reg[PTR_W-1:0]];
        end
        if (cmd.update) begin
            store_mem[pos_reg[PTR_W-1:0]] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= sample;
        end
        if (cmd.div_load) begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (fits) begin
                rem_reg <= COUNT_W'(rem_shift - divisor);
            end else begin
                rem_reg <= rem_shift[COUNT_W-1:0];
            end
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
        if (cmd.out_load) begin
            avg_reg <= neg_reg ? -quo_reg[SAMPLE_WIDTH-1:0] : quo_reg[SAMPLE_WIDTH-1:0];
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign average         = avg_reg;
    assign m_valid         = m_valid_reg;

endmodule

[hw/rtl/mavg_ctrl.sv]
module mavg_ctrl #(
    parameter int DIV_STEPS = 22
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  mavg_pkg::mavg_status_t status,
    output mavg_pkg::mavg_cmd_t    cmd
);
    import mavg_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;

    // input beat taken: idle and no window length write pending
    assign take = s_valid && !cfg_valid && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready     = 1'b1;
                s_ready       = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                cmd.clear     = take && (s_command == CMD_CLEAR);
                cmd.accept    = take && (s_command == CMD_SAMPLE);
                if (cmd.accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[test/tb_moving_average_filter.sv]
`timescale 1ns / 1ps

module tb_moving_average_filter;
    import mavg_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int SAMPLE_W    = 16;
    localparam int DATA_W      = 16;
    localparam int SETTLE      = 40;      // outlasts a sample's trip through the block
    localparam int N_PHASES    = 12;
    localparam int PHASE_BEATS = 85;
    localparam int HOLD_PHASE  = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] smp;
    } beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    moving_average_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // stimulus and expectation stores
    beat_t               beat_q[$];
    logic [SAMPLE_W-1:0] average_q[$];
    int                  errors = 0;
    int                  send_idle = 23;
    int                  recv_idle = 85;
    bit                  in_taken = 1'b0;
    bit                  hold_go = 1'b0;
    int                  hold_left = 0;
    int                  cycle_count = 0;

    // predicted window state
    logic signed [SAMPLE_W-1:0] win_store [STORE_DEPTH];
    logic [CFG_W-1:0]           win_len;
    int                         win_pos;
    int                         win_fill;
    longint                     win_sum;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void clear_window();
        win_pos  = 0;
        win_fill = 0;
        win_sum  = 0;
    endfunction

    // length 0 acts as 1, anything past the store depth saturates
    function automatic int window_span();
        if (win_len == 0) return 1;
        if (win_len > STORE_DEPTH) return STORE_DEPTH;
        return int'(win_len);
    endfunction

    // Advance the running sum by one beat; a sample beat queues its average.
    function automatic void advance_window(input logic cmd, input logic [SAMPLE_W-1:0] raw);
        int                         span;
        int                         slot;
        logic signed [SAMPLE_W-1:0] smp;
        smp  = raw;
        span = window_span();
        if (cmd == CMD_CLEAR) begin
            clear_window();
            return;
        end
        slot = win_pos % span;
        if (win_fill < span) begin
            win_store[slot] = smp;
            win_sum += smp;
            win_fill++;
        end else begin
            // full window: swap the oldest sample out of the sum
            win_sum += longint'(smp) - longint'(win_store[slot]);
            win_store[slot] = smp;
        end
        win_pos = (slot + 1) % span;
        // SV signed divide truncates toward zero
        average_q.push_back(SAMPLE_W'(win_sum / longint'(win_fill)));
    endfunction

    // --------------------------------------------------------------
    // Monitor: check result beats, predict on accepted input beats.
    // Sampled at the rising edge, before the block's registers move.
    // --------------------------------------------------------------
    logic [SAMPLE_W-1:0] want_avg;

    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (average_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with no sample pending",
                                              m_tdata[SAMPLE_W-1:0]));
                end else begin
                    want_avg = average_q.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want_avg)
                        report_mismatch($sformatf("average %h, want %h",
                                                  m_tdata[SAMPLE_W-1:0], want_avg));
                end
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                advance_window(s_tuser, s_tdata[SAMPLE_W-1:0]);
            end
        end
    end

    // --------------------------------------------------------------
    // Driver: offers the next queued beat at the falling edge once the
    // current one is gone, idling at random per send_idle.
    // --------------------------------------------------------------
    beat_t drv_beat;

    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (beat_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
                drv_beat = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_beat.cmd;
                s_tdata  <= DATA_W'(drv_beat.smp);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle);
    end

    initial begin
        wait (hold_go);
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
            @(posedge aclk);
            hold_left--;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("moving_average_filter: mismatch");
            $finish;
        end
    end

    // --------------------------------------------------------------
    // Sequencer helpers
    // --------------------------------------------------------------
    task automatic push_beat(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        beat_t b;
        b.cmd = cmd;
        b.smp = smp;
        beat_q.push_back(b);
    endtask

    // extremes, values near zero (truncation of negative sums), full range
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9, 0))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return SAMPLE_W'($urandom_range(16, 0) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // wait until every beat is in and every average is out, then let any
    // clear still in flight settle
    task automatic drain();
        while (beat_q.size() != 0 || s_tvalid || average_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] span);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= span;
        do @(posedge aclk); while (!cfg_ready);
        win_len = span;
        clear_window();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // --------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------
    logic [CFG_W-1:0] fixed_spans [7] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd2, 7'd3};
    logic [CFG_W-1:0] span_now;

    initial begin
        win_len = WINDOW_RESET;
        clear_window();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, default window of 8
        repeat (8) push_beat(CMD_SAMPLE, 16'h7FFF);   // full window at +max
        repeat (8) push_beat(CMD_SAMPLE, 16'h8000);   // wrap, all replaced by -max
        push_beat(CMD_CLEAR, 16'hFFFF);               // clear ignores sample bits
        push_beat(CMD_SAMPLE, 16'hFFFF);              // -1
        push_beat(CMD_SAMPLE, 16'h0000);              // -1/2 -> 0
        push_beat(CMD_SAMPLE, 16'hFFFD);              // -4/3 -> -1
        push_beat(CMD_SAMPLE, 16'h0005);              // 1/4 -> 0
        push_beat(CMD_CLEAR, 16'h0000);
        push_beat(CMD_SAMPLE, 16'h0001);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle = (ph < 4) ? 23 : (ph < 8) ? 85 : 0;
            recv_idle = (ph < 4) ? 85 : (ph < 8) ? 23 : 0;
            if (ph < 7)
                span_now = fixed_spans[ph];
            else if ($urandom_range(3, 0) == 0)
                span_now = CFG_W'($urandom_range(127, 0));
            else
                span_now = CFG_W'($urandom_range(STORE_DEPTH, 1));
            // config write also empties whatever window the last phase left
            set_window(span_now);
            if (ph == HOLD_PHASE) hold_go = 1'b1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(99, 0) < 3)
                    push_beat(CMD_CLEAR, SAMPLE_W'($urandom));
                else
                    push_beat(CMD_SAMPLE, pick_sample());
            end
        end

        drain();
        if (errors == 0)
            $display("moving_average_filter: match");
        else
            $display("moving_average_filter: mismatch");
        $finish;
    end

endmodule
